FILE: src/ostb_pkg.sv
package ostb_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int ID_W           = 3;
    localparam int COUNT_W        = 16;

    typedef logic [1:0] t_action;
    localparam t_action ACT_CREATE  = 2'd0;
    localparam t_action ACT_RESTART = 2'd1;
    localparam t_action ACT_TICK    = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_NOREG = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        t_action            action;
        logic [ID_W-1:0]    timer_id;
        logic               has_callback;
        logic [COUNT_W-1:0] period;
        logic               start_req;
    } t_cmd;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] which_timer;
        logic            status;
        logic            last;
    } t_result;

    typedef struct packed {
        logic [COUNT_W-1:0] count_nx;
        logic               expired;
    } t_step;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_FLUSH
    } t_state;

endpackage

FILE: src/ostb_ram.sv
module ostb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ostb_inc_cmp.sv
module ostb_inc_cmp
    import ostb_pkg::*;
(
    input  logic [COUNT_W-1:0] i_count,
    input  logic [COUNT_W-1:0] i_period,
    output t_step              o_step
);

    logic [COUNT_W-1:0] w_nx;

    always_comb begin
        w_nx = (i_count == COUNT_MAX) ? i_count : i_count + 1'b1;
        o_step.count_nx = w_nx;
        o_step.expired  = (w_nx >= i_period);
    end

endmodule

FILE: src/one_shot_timer_bank_unit.sv
// One-shot timer bank. A transaction is accepted when start is high and busy is low.
// Create and restart need no walk; a restart status shows on o_strobe/o_result
// in the cycle after acceptance. A tick walks all NUM_TIMERS timers through one
// shared increment/compare unit fed by the single read port of the period and
// count memories: an idle timer is skipped in S_READ, a running timer goes
// through S_READ and S_UPDATE, and S_FLUSH closes the walk; busy stays high through S_FLUSH.
// Each result is shown for exactly one cycle and must be captured then; the
// receiver cannot stall. The last result of a transaction carries last = 1.
module one_shot_timer_bank_unit
    import ostb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int XW = IW + ID_W;

    t_state r_state, n_state;

    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         r_pend_id;
    logic                  r_pend;
    logic [NUM_TIMERS-1:0] r_registered;
    logic [NUM_TIMERS-1:0] r_running;
    logic                  r_strobe, n_strobe;
    t_result               r_result, n_result;

    logic          w_acc;
    logic [XW-1:0] w_id_ext;
    logic [IW-1:0] w_id;
    logic          w_id_ok;
    logic          w_create;
    logic          w_restart;
    logic          w_restart_ok;
    logic          w_active;
    logic          w_last_idx;
    logic          w_rd_en;
    logic          w_update;
    logic          w_advance;
    logic          w_flush;

    logic [COUNT_W-1:0] w_period_rd;
    logic [COUNT_W-1:0] w_count_rd;
    logic               w_cnt_we;
    logic [IW-1:0]      w_cnt_waddr;
    logic [COUNT_W-1:0] w_cnt_wdata;
    t_step              w_step;
    logic [XW-1:0]      w_pend_ext;

    assign busy       = (r_state != S_IDLE);
    assign w_acc      = start && !busy;
    assign w_id_ext   = XW'(i_cmd.timer_id);
    assign w_id       = w_id_ext[IW-1:0];
    assign w_id_ok    = (w_id_ext < XW'(NUM_TIMERS));
    assign w_create   = w_acc && (i_cmd.action == ACT_CREATE) && w_id_ok;
    assign w_restart  = w_acc && (i_cmd.action == ACT_RESTART);
    assign w_restart_ok = w_restart && w_id_ok && r_registered[w_id];
    assign w_active   = r_registered[r_idx] && r_running[r_idx];
    assign w_last_idx = (r_idx == IW'(NUM_TIMERS - 1));
    assign w_pend_ext = XW'(r_pend_id);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (i_cmd.action == ACT_TICK)) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_active) begin
                    n_state = S_UPDATE;
                end else if (w_last_idx) begin
                    n_state = S_FLUSH;
                end
            end
            S_UPDATE: begin
                n_state = w_last_idx ? S_FLUSH : S_READ;
            end
            S_FLUSH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_rd_en   = 1'b0;
        w_update  = 1'b0;
        w_advance = 1'b0;
        w_flush   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_READ: begin
                w_rd_en   = w_active;
                w_advance = !w_active;
            end
            S_UPDATE: begin
                w_update  = 1'b1;
                w_advance = 1'b1;
            end
            S_FLUSH: begin
                w_flush = 1'b1;
            end
            default: begin
            end
        endcase
    end

    ostb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_period_ram (
        .i_clk   (i_clk),
        .i_we    (w_create),
        .i_waddr (w_id),
        .i_wdata (i_cmd.period),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_period_rd)
    );

    assign w_cnt_we    = w_create || w_restart_ok || w_update;
    assign w_cnt_waddr = w_update ? r_idx : w_id;
    assign w_cnt_wdata = w_update ? w_step.count_nx : '0;

    ostb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_TIMERS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_cnt_we),
        .i_waddr (w_cnt_waddr),
        .i_wdata (w_cnt_wdata),
        .i_re    (w_rd_en),
        .i_raddr (r_idx),
        .o_rdata (w_count_rd)
    );

    ostb_inc_cmp u_inc_cmp (
        .i_count  (w_count_rd),
        .i_period (w_period_rd),
        .o_step   (w_step)
    );

    // result staging: an expiry is held until the next one (or the end) decides last
    always_comb begin
        n_strobe = 1'b0;
        n_result = r_result;
        if (w_restart) begin
            n_strobe             = 1'b1;
            n_result.kind        = KIND_STATUS;
            n_result.which_timer = i_cmd.timer_id;
            n_result.status      = w_restart_ok ? ST_OK : ST_NOREG;
            n_result.last        = 1'b1;
        end else if ((w_update && w_step.expired && r_pend) || (w_flush && r_pend)) begin
            n_strobe             = 1'b1;
            n_result.kind        = KIND_EXPIRY;
            n_result.which_timer = w_pend_ext[ID_W-1:0];
            n_result.status      = ST_OK;
            n_result.last        = w_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pend       <= 1'b0;
            r_registered <= '0;
            r_running    <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (r_state == S_IDLE) begin
                r_idx <= '0;
            end else if (w_advance) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_create) begin
                r_registered[w_id] <= i_cmd.has_callback;
                r_running[w_id]    <= i_cmd.start_req;
            end
            if (w_restart_ok) begin
                r_running[w_id] <= i_cmd.start_req;
            end
            if (w_update && w_step.expired) begin
                r_running[r_idx] <= 1'b0;
                r_pend           <= 1'b1;
            end else if (w_flush) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        if (w_update && w_step.expired) begin
            r_pend_id <= r_idx;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

FILE: src/ostb_checker.sv
module ostb_checker
    import ostb_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input t_cmd    i_cmd,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);

    logic w_acc;
    assign w_acc = start && !busy;

    a_restart_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd.action == ACT_RESTART) |=>
            (o_strobe && o_result.kind == KIND_STATUS && o_result.last
             && o_result.which_timer == $past(i_cmd.timer_id)))
        else $error("restart transaction did not report");

    a_status_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == KIND_STATUS) |->
            $past(w_acc && i_cmd.action == ACT_RESTART))
        else $error("status result without restart");

    a_create_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd.action == ACT_CREATE) |=> !o_strobe)
        else $error("create produced a result");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd.action == ACT_TICK) |=> busy)
        else $error("tick did not start walk");

    a_expiry_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.kind == KIND_EXPIRY) |-> $past(busy))
        else $error("expiry outside tick walk");

endmodule

bind one_shot_timer_bank_unit ostb_checker u_ostb_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_cmd    (i_cmd),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
